@@ rtl/astar_open_list_queue_defines.svh @@
// ----------------------------------------------------------------------------
// astar_open_list_queue_defines
// Assertion macros shared by the open list checker.
// ----------------------------------------------------------------------------
`ifndef ASTAR_OPEN_LIST_QUEUE_DEFINES_SVH
`define ASTAR_OPEN_LIST_QUEUE_DEFINES_SVH

// checked only while out of reset
`define AOLQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define AOLQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/aolq_pkg.sv @@
// ----------------------------------------------------------------------------
// aolq_pkg
// Shared codes and types of the open list queue.
// ----------------------------------------------------------------------------
package aolq_pkg;

  localparam int NODE_W = 10;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OPEN  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic ins;
    logic pop;
    logic rem;
  } aolq_ctl_t;

endpackage

@@ rtl/aolq_cell.sv @@
// ----------------------------------------------------------------------------
// aolq_cell
// One slot of the sorted queue: compares against the incoming key and shifts
// its entry towards either neighbour.
// ----------------------------------------------------------------------------
module aolq_cell #(
  parameter int COST_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  aolq_pkg::aolq_ctl_t        ctl,
  input  logic [aolq_pkg::NODE_W-1:0] new_node,
  input  logic [COST_BITS:0]         new_total,
  input  logic [COST_BITS-1:0]       new_est,
  input  logic                       left_ge,
  input  logic                       left_valid,
  input  logic [aolq_pkg::NODE_W-1:0] left_node,
  input  logic [COST_BITS:0]         left_total,
  input  logic [COST_BITS-1:0]       left_est,
  input  logic                       right_valid,
  input  logic [aolq_pkg::NODE_W-1:0] right_node,
  input  logic [COST_BITS:0]         right_total,
  input  logic [COST_BITS-1:0]       right_est,
  input  logic                       match_in,
  output logic                       ge,
  output logic                       match_out,
  output logic                       valid,
  output logic [aolq_pkg::NODE_W-1:0] node,
  output logic [COST_BITS:0]         total,
  output logic [COST_BITS-1:0]       est
);
  import aolq_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [NODE_W-1:0]    node_r, node_nxt;
  logic [COST_BITS:0]   total_r, total_nxt;
  logic [COST_BITS-1:0] est_r, est_nxt;
  logic                 less;

  assign less      = (total_r < new_total) || ((total_r == new_total) && (est_r < new_est));
  assign ge        = !valid_r || !less;
  assign match_out = match_in || (valid_r && (node_r == new_node));

  always_comb begin
    valid_nxt = valid_r;
    node_nxt  = node_r;
    total_nxt = total_r;
    est_nxt   = est_r;
    if (ctl.ins && ge && !left_ge) begin
      valid_nxt = 1'b1;
      node_nxt  = new_node;
      total_nxt = new_total;
      est_nxt   = new_est;
    end else if (ctl.ins && ge) begin
      valid_nxt = left_valid;
      node_nxt  = left_node;
      total_nxt = left_total;
      est_nxt   = left_est;
    end else if (ctl.pop || (ctl.rem && match_out)) begin
      valid_nxt = right_valid;
      node_nxt  = right_node;
      total_nxt = right_total;
      est_nxt   = right_est;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r  <= node_nxt;
    total_r <= total_nxt;
    est_r   <= est_nxt;
  end

  assign valid = valid_r;
  assign node  = node_r;
  assign total = total_r;
  assign est   = est_r;

endmodule

@@ rtl/aolq_out_buf.sv @@
// ----------------------------------------------------------------------------
// aolq_out_buf
// Two-entry result buffer between the cell chain and the result channel.
// ----------------------------------------------------------------------------
module aolq_out_buf #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [W-1:0] out_data
);

  logic [1:0]   cnt_r, cnt_nxt;
  logic [W-1:0] d0_r, d0_nxt, d1_r, d1_nxt;
  logic         pop;

  assign pop = (cnt_r != 2'd0) && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    d0_nxt  = d0_r;
    d1_nxt  = d1_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          d0_nxt = push_data;
        end else begin
          d1_nxt = push_data;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        d0_nxt  = d1_r;
        cnt_nxt = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          d0_nxt = push_data;
        end else begin
          d0_nxt = d1_r;
          d1_nxt = push_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
  end

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = d0_r;

endmodule

@@ rtl/astar_open_list_queue.sv @@
// ----------------------------------------------------------------------------
// astar_open_list_queue
// Open list of a path search held as a sorted queue in a row of cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one command per transfer - insert a node
// with cost so far and estimate, pop the best node, or remove a given node.
// Entries are kept ordered by total cost, then estimate, newest first on a
// full tie. Every cell compares its entry against the command in parallel,
// so each command completes in the cycle it is accepted.
// Result channel (out_valid/out_stall): exactly one result per command,
// valid the cycle after the input transfer when no earlier result waits:
// popped node and total, a status code and the occupancy after the command.
// Throughput: one command per unstalled cycle. A two-entry result buffer
// sits before the result channel; in_stall rises only when both entries are
// held, so a stalled receiver stops intake after two pending results.
// Reset: synchronous, active low; empties the queue and the result buffer.
// No clearing pass is needed, the block takes commands straight after reset.
// ----------------------------------------------------------------------------
module astar_open_list_queue #(
  parameter int CAPACITY  = 16,
  parameter int COST_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_command,
  input  logic [aolq_pkg::NODE_W-1:0]         in_node_id,
  input  logic [COST_BITS-1:0]                in_cost_so_far,
  input  logic [COST_BITS-1:0]                in_estimate,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [aolq_pkg::NODE_W-1:0]         out_node,
  output logic [COST_BITS:0]                  out_total,
  output logic [1:0]                          out_status,
  output logic [$clog2(CAPACITY + 1)-1:0]     out_occupancy
);
  import aolq_pkg::*;

  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int RES_W   = NODE_W + COST_BITS + 1 + 2 + COUNT_W;

  logic                 accept;
  logic                 buf_full;
  logic [COST_BITS:0]   new_total;
  logic                 any_match;
  logic                 q_full;
  logic                 q_empty;
  aolq_ctl_t            ctl;
  logic [1:0]           status;
  logic [NODE_W-1:0]    res_node;
  logic [COST_BITS:0]   res_total;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [RES_W-1:0]     res_data, buf_data;

  logic                 c_ge    [CAPACITY];
  logic                 c_match [CAPACITY];
  logic                 c_valid [CAPACITY];
  logic [NODE_W-1:0]    c_node  [CAPACITY];
  logic [COST_BITS:0]   c_total [CAPACITY];
  logic [COST_BITS-1:0] c_est   [CAPACITY];

  assign accept    = in_valid && !in_stall;
  assign in_stall  = buf_full;
  assign new_total = {1'b0, in_cost_so_far} + {1'b0, in_estimate};
  assign any_match = c_match[CAPACITY-1];
  assign q_full    = (count_r == COUNT_W'(CAPACITY));
  assign q_empty   = (count_r == '0);

  always_comb begin
    ctl    = '0;
    status = ST_OK;
    unique case (in_command)
      CMD_INSERT: begin
        if (any_match) begin
          status = ST_OPEN;
        end else if (q_full) begin
          status = ST_FULL;
        end else begin
          ctl.ins = accept;
        end
      end
      CMD_POP: begin
        if (q_empty) begin
          status = ST_EMPTY;
        end else begin
          ctl.pop = accept;
        end
      end
      CMD_REMOVE: begin
        if (!any_match) begin
          status = ST_OPEN;
        end else begin
          ctl.rem = accept;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + COUNT_W'(1);
    end else if (ctl.pop || ctl.rem) begin
      count_nxt = count_r - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                 l_ge, l_valid, r_valid, m_in;
      logic [NODE_W-1:0]    l_node, r_node;
      logic [COST_BITS:0]   l_total, r_total;
      logic [COST_BITS-1:0] l_est, r_est;

      if (i == 0) begin : g_head
        assign l_ge    = 1'b0;
        assign l_valid = 1'b0;
        assign l_node  = '0;
        assign l_total = '0;
        assign l_est   = '0;
        assign m_in    = 1'b0;
      end else begin : g_mid
        assign l_ge    = c_ge[i-1];
        assign l_valid = c_valid[i-1];
        assign l_node  = c_node[i-1];
        assign l_total = c_total[i-1];
        assign l_est   = c_est[i-1];
        assign m_in    = c_match[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign r_valid = 1'b0;
        assign r_node  = '0;
        assign r_total = '0;
        assign r_est   = '0;
      end else begin : g_body
        assign r_valid = c_valid[i+1];
        assign r_node  = c_node[i+1];
        assign r_total = c_total[i+1];
        assign r_est   = c_est[i+1];
      end

      aolq_cell #(
        .COST_BITS(COST_BITS)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .new_node   (in_node_id),
        .new_total  (new_total),
        .new_est    (in_estimate),
        .left_ge    (l_ge),
        .left_valid (l_valid),
        .left_node  (l_node),
        .left_total (l_total),
        .left_est   (l_est),
        .right_valid(r_valid),
        .right_node (r_node),
        .right_total(r_total),
        .right_est  (r_est),
        .match_in   (m_in),
        .ge         (c_ge[i]),
        .match_out  (c_match[i]),
        .valid      (c_valid[i]),
        .node       (c_node[i]),
        .total      (c_total[i]),
        .est        (c_est[i])
      );
    end
  endgenerate

  assign res_node  = ctl.pop ? c_node[0] : '0;
  assign res_total = ctl.pop ? c_total[0] : '0;
  assign res_data  = {res_node, res_total, status, count_nxt};

  aolq_out_buf #(
    .W(RES_W)
  ) u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_data(res_data),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (buf_data)
  );

  assign {out_node, out_total, out_status, out_occupancy} = buf_data;

endmodule

@@ rtl/aolq_checker.sv @@
// ----------------------------------------------------------------------------
// aolq_checker
// Result channel checks for the open list queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "astar_open_list_queue_defines.svh"

module aolq_checker #(
  parameter int CAPACITY  = 16,
  parameter int COST_BITS = 16,
  parameter int COUNT_W   = $clog2(CAPACITY + 1)
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [aolq_pkg::NODE_W-1:0] out_node,
  input logic [COST_BITS:0]          out_total,
  input logic [1:0]                  out_status,
  input logic [COUNT_W-1:0]          out_occupancy
);
  import aolq_pkg::*;

  localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAPACITY);

  logic                                     res_failed;
  logic                                     res_zero;
  logic                                     res_empty;
  logic                                     res_full;
  logic                                     res_held;
  logic [NODE_W+COST_BITS+1+2+COUNT_W-1:0]  res_word;

  assign res_failed = out_valid && (out_status != ST_OK);
  assign res_zero   = (out_node == '0) && (out_total == '0);
  assign res_empty  = out_valid && (out_status == ST_EMPTY);
  assign res_full   = out_valid && (out_status == ST_FULL);
  assign res_held   = out_valid && out_stall;
  assign res_word   = {out_node, out_total, out_status, out_occupancy};

  `AOLQ_ASSERT(a_occ_bound, out_valid |-> (out_occupancy <= CAP), "occupancy above capacity")
  `AOLQ_ASSERT(a_fail_zero, res_failed |-> res_zero, "failed command carries a node")
  `AOLQ_ASSERT(a_empty_occ, res_empty |-> (out_occupancy == '0), "empty status with entries")
  `AOLQ_ASSERT(a_full_occ, res_full |-> (out_occupancy == CAP), "full status below capacity")
  `AOLQ_ASSERT(a_hold, res_held |=> (out_valid && $stable(res_word)), "stalled result changed")

endmodule

bind astar_open_list_queue aolq_checker #(
  .CAPACITY (CAPACITY),
  .COST_BITS(COST_BITS),
  .COUNT_W  (COUNT_W)
) u_aolq_checker (.*);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted open list queue.
// ----------------------------------------------------------------------------
// A directed opening covers the empty pop, refused ids, cost extremes,
// tie ordering, the unused command and a queue run up to full. Random
// commands follow in randomly chosen fill and drain phases over a small id pool,
// so that inserts, pops and removes mostly hit live entries. Each accepted
// transfer runs through a local copy of the queue, and every result is
// checked field by field against it, in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aolq_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int COST_BITS    = 16;
  localparam int NODES        = 1024;
  localparam logic [1:0] CMD_IDLE = 2'd3;  // unused code, no action
  localparam int RANDOM_ITEMS = 1025;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [NODE_W-1:0]    node;
    logic [COST_BITS-1:0] cost;
    logic [COST_BITS-1:0] est;
  } olq_cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [COST_BITS:0] total;
    logic [1:0]         status;
    logic [4:0]         occ;
  } olq_res_t;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_command     = CMD_IDLE;
  logic [NODE_W-1:0]    in_node_id     = '0;
  logic [COST_BITS-1:0] in_cost_so_far = '0;
  logic [COST_BITS-1:0] in_estimate    = '0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic [NODE_W-1:0]    out_node;
  logic [COST_BITS:0]   out_total;
  logic [1:0]           out_status;
  logic [4:0]           out_occupancy;

  astar_open_list_queue dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_node_id     (in_node_id),
    .in_cost_so_far (in_cost_so_far),
    .in_estimate    (in_estimate),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_node       (out_node),
    .out_total      (out_total),
    .out_status     (out_status),
    .out_occupancy  (out_occupancy)
  );

  always #4 clk = ~clk;

  olq_cmd_t pending[$];
  olq_res_t expected[$];
  int       cycles = 0;
  int       fails  = 0;
  int       status_seen[4] = '{0, 0, 0, 0};
  int       peak_occ = 0;

  // local copy of the open list
  logic [NODE_W-1:0]    open_node  [CAPACITY];
  logic [COST_BITS:0]   open_total [CAPACITY];
  logic [COST_BITS-1:0] open_est   [CAPACITY];
  logic [NODES-1:0]     is_open    = '0;
  int                   open_count = 0;

  function automatic olq_res_t apply_command(olq_cmd_t c);
    olq_res_t           r;
    logic [COST_BITS:0] t;
    int                 p;
    int                 i;
    r = '0;
    r.status = ST_OK;
    case (c.cmd)
      CMD_INSERT: begin
        t = {1'b0, c.cost} + {1'b0, c.est};
        if (is_open[c.node]) begin
          r.status = ST_OPEN;
        end else if (open_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          p = 0;
          while (p < open_count && (open_total[p] < t ||
                 (open_total[p] == t && open_est[p] < c.est)))
            p++;
          for (i = open_count; i > p; i--) begin
            open_node[i]  = open_node[i-1];
            open_total[i] = open_total[i-1];
            open_est[i]   = open_est[i-1];
          end
          open_node[p]  = c.node;
          open_total[p] = t;
          open_est[p]   = c.est;
          open_count++;
          is_open[c.node] = 1'b1;
        end
      end
      CMD_POP: begin
        if (open_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.node  = open_node[0];
          r.total = open_total[0];
          is_open[open_node[0]] = 1'b0;
          for (i = 0; i + 1 < open_count; i++) begin
            open_node[i]  = open_node[i+1];
            open_total[i] = open_total[i+1];
            open_est[i]   = open_est[i+1];
          end
          open_count--;
        end
      end
      CMD_REMOVE: begin
        if (!is_open[c.node]) begin
          r.status = ST_OPEN;
        end else begin
          p = 0;
          while (p < open_count && open_node[p] != c.node)
            p++;
          if (p < open_count) begin
            for (i = p; i + 1 < open_count; i++) begin
              open_node[i]  = open_node[i+1];
              open_total[i] = open_total[i+1];
              open_est[i]   = open_est[i+1];
            end
            open_count--;
          end
          is_open[c.node] = 1'b0;
        end
      end
      default: ;
    endcase
    r.occ = open_count[4:0];
    return r;
  endfunction

  // mostly short gaps, a few long ones, and quiet stretches with none
  function automatic int pick_gap();
    int r;
    if ((cycles % 3000) < 600) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [COST_BITS-1:0] pick_cost();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return COST_BITS'($urandom_range(0, 7));  // frequent ties
    if (r < 32) return $urandom_range(0, 1) ? '1 : '0;
    return COST_BITS'($urandom_range(0, 65535));
  endfunction

  task automatic add(logic [1:0] cmd, int node, logic [COST_BITS-1:0] cost,
                     logic [COST_BITS-1:0] est);
    olq_cmd_t c;
    c.cmd  = cmd;
    c.node = node[NODE_W-1:0];
    c.cost = cost;
    c.est  = est;
    pending.push_back(c);
  endtask

  // driver: pending[0] is the command on the bus while in_valid is high
  int in_gap = 0;
  always @(posedge clk) begin
    logic load;
    if (rst_n) begin
      load = !in_valid || !in_stall;
      if (in_valid && !in_stall) begin
        expected.push_back(apply_command(pending.pop_front()));
        in_gap = pick_gap();
      end
      if (load) begin
        if (in_gap > 0 || pending.size() == 0) begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap--;
        end else begin
          in_valid       <= 1'b1;
          in_command     <= pending[0].cmd;
          in_node_id     <= pending[0].node;
          in_cost_so_far <= pending[0].cost;
          in_estimate    <= pending[0].est;
        end
      end
    end
  end

  // monitor
  int out_hold = 0;
  always @(posedge clk) begin
    olq_res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected.size() == 0) begin
          $error("result with none expected: node %0d status %0d", out_node, out_status);
          fails++;
        end else begin
          want = expected.pop_front();
          if (out_node !== want.node) begin
            $error("out_node: expected %0d, got %0d", want.node, out_node);
            fails++;
          end
          if (out_total !== want.total) begin
            $error("out_total: expected %0d, got %0d", want.total, out_total);
            fails++;
          end
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, got %0d", want.status, out_status);
            fails++;
          end
          if (out_occupancy !== want.occ) begin
            $error("out_occupancy: expected %0d, got %0d", want.occ, out_occupancy);
            fails++;
          end
          status_seen[want.status]++;
          if (want.occ > peak_occ) peak_occ = want.occ;
        end
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
        out_hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, expected.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int n;
    int r;
    int base;
    int node;
    bit drain;
    logic [1:0] cmd;

    // directed opening
    add(CMD_POP, 0, 0, 0);                // pop from empty queue
    add(CMD_REMOVE, 5, 0, 0);             // remove of id not open
    add(CMD_INSERT, 0, '0, '0);
    add(CMD_INSERT, 1023, '1, '1);        // largest total
    add(CMD_INSERT, 0, 1, 1);             // duplicate id
    add(CMD_INSERT, 10, 100, 50);
    add(CMD_INSERT, 11, 100, 50);         // full tie, newest first
    add(CMD_INSERT, 12, 50, 100);         // same total, larger estimate
    add(CMD_INSERT, 13, 120, 30);         // same total, smaller estimate
    add(CMD_IDLE, 1023, '1, '1);
    add(CMD_REMOVE, 11, 0, 0);            // from the middle
    add(CMD_REMOVE, 11, 0, 0);            // already gone
    for (n = 0; n < 12; n++)
      add(CMD_INSERT, 200 + n, pick_cost(), pick_cost());  // last one finds it full
    add(CMD_INSERT, 0, 0, 0);             // duplicate wins over full
    add(CMD_POP, 0, 0, 0);

    // random phases of filling and draining over a sliding id pool
    drain = 1'b0;
    base  = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) drain = $urandom_range(0, 1);
      if (n % 200 == 0) base = $urandom_range(0, NODES - 1);
      r = $urandom_range(0, 99);
      if (r < 3) cmd = CMD_IDLE;
      else if (r < (drain ? 35 : 75)) cmd = CMD_INSERT;
      else if (r < (drain ? 75 : 88)) cmd = CMD_POP;
      else cmd = CMD_REMOVE;
      if ($urandom_range(0, 19) == 0) node = $urandom_range(0, NODES - 1);
      else node = (base + $urandom_range(0, 23)) % NODES;
      add(cmd, node, pick_cost(), pick_cost());
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (pending.size() != 0 || expected.size() != 0);
    repeat (8) @(posedge clk);

    $display("checked %0d results: %0d ok, %0d open/not open, %0d full, %0d empty",
             status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3],
             status_seen[ST_OK], status_seen[ST_OPEN], status_seen[ST_FULL],
             status_seen[ST_EMPTY]);
    $display("peak occupancy %0d of %0d, %0d cycles", peak_occ, CAPACITY, cycles);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/aolq_pkg.sv
rtl/aolq_cell.sv
rtl/aolq_out_buf.sv
rtl/astar_open_list_queue.sv
rtl/aolq_checker.sv
tb/tb.sv
